FILE: hw/rtl/scaled_transform_compose_core_defines.svh
// ============================================================================
// Scaled transform compose core - assertion macros
// Shared property wrappers, clocked on aclk and disabled during reset.
// ============================================================================
`ifndef SCALED_TRANSFORM_COMPOSE_CORE_DEFINES_SVH
`define SCALED_TRANSFORM_COMPOSE_CORE_DEFINES_SVH

// Implication or plain expression that must hold at every edge out of reset
`define STC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Condition that must never be seen out of reset
`define STC_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) else $error(msg);

`endif

FILE: hw/rtl/stc_pkg.sv
// ============================================================================
// stc_pkg
// Types, constants and helpers shared by the scaled transform compose core.
// ============================================================================
package stc_pkg;

    // Matrix element: rotation*scale in 2^-24 units, or translation in Q24.8
    typedef logic signed [31:0] elem_t;

    // Rotation term in 2^-30 units
    typedef logic signed [33:0] rot_t;

    // Affine matrix: 3x3 rotation*scale block plus translation row
    typedef struct packed {
        elem_t [2:0][2:0] r;
        elem_t [2:0]      t;
    } mat_t;

    // Row beat control between sequencer and multiplier
    typedef struct packed {
        logic       valid;
        logic [1:0] row;
        logic       last;
    } row_ctl_t;

    // Configuration register map
    typedef enum logic [2:0] {
        REG_PARENT_ROTATION = 3'd0,
        REG_PARENT_OFFSET_X = 3'd1,
        REG_PARENT_OFFSET_Y = 3'd2,
        REG_PARENT_OFFSET_Z = 3'd3,
        REG_PARENT_SCALE_X  = 3'd4,
        REG_PARENT_SCALE_Y  = 3'd5,
        REG_PARENT_SCALE_Z  = 3'd6
    } reg_idx_t;

    localparam logic [1:0]  LAST_ROW         = 2'd3;
    localparam logic [63:0] PARENT_ROT_RESET = 64'h7FFF_0000_0000_0000;
    localparam logic [15:0] SCALE_ONE        = 16'd4096;
    localparam logic signed [47:0] ENTRY_ONE = 48'sd65536;
    localparam logic signed [47:0] SAT_MAX   = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] SAT_MIN   = 48'sh8000_0000_0000;

    // 1 - 2(p + q), units of 2^-30
    function automatic rot_t rot_diag(input logic signed [31:0] p,
                                      input logic signed [31:0] q);
        logic signed [34:0] s;
        s = 35'sh0_4000_0000 - ((35'(p) + 35'(q)) <<< 1);
        return s[33:0];
    endfunction

    // 2(p + q) or 2(p - q), units of 2^-30
    function automatic rot_t rot_cross(input logic signed [31:0] p,
                                       input logic signed [31:0] q,
                                       input logic               sub);
        logic signed [34:0] s;
        s = sub ? ((35'(p) - 35'(q)) <<< 1) : ((35'(p) + 35'(q)) <<< 1);
        return s[33:0];
    endfunction

endpackage

FILE: hw/rtl/stc_build.sv
// ============================================================================
// stc_build
// Three-stage quaternion/scale/translation to affine matrix builder.
// ============================================================================
module stc_build (
    input  logic                  aclk,
    input  logic [2:0]            stage_en,
    input  logic signed [15:0]    quat_x,
    input  logic signed [15:0]    quat_y,
    input  logic signed [15:0]    quat_z,
    input  logic signed [15:0]    quat_w,
    input  logic signed [31:0]    pos_x,
    input  logic signed [31:0]    pos_y,
    input  logic signed [31:0]    pos_z,
    input  logic signed [15:0]    scale_x,
    input  logic signed [15:0]    scale_y,
    input  logic signed [15:0]    scale_z,
    output stc_pkg::mat_t         mat
);
    import stc_pkg::*;

    localparam int P_XX = 0, P_YY = 1, P_ZZ = 2, P_XY = 3, P_XZ = 4;
    localparam int P_YZ = 5, P_WX = 6, P_WY = 7, P_WZ = 8;

    logic signed [31:0] prod_next [9];
    logic signed [31:0] prod_reg  [9];
    logic signed [31:0] pos1_reg  [3];
    logic signed [31:0] pos2_reg  [3];
    logic signed [15:0] scl1_reg  [3];
    logic signed [15:0] scl2_reg  [3];
    rot_t               rot_next  [9];
    rot_t               rot_reg   [9];
    logic signed [49:0] scaled    [9];
    mat_t               mat_next;
    mat_t               mat_reg;

    // Stage 1: component products
    always_comb begin
        prod_next[P_XX] = quat_x * quat_x;
        prod_next[P_YY] = quat_y * quat_y;
        prod_next[P_ZZ] = quat_z * quat_z;
        prod_next[P_XY] = quat_x * quat_y;
        prod_next[P_XZ] = quat_x * quat_z;
        prod_next[P_YZ] = quat_y * quat_z;
        prod_next[P_WX] = quat_w * quat_x;
        prod_next[P_WY] = quat_w * quat_y;
        prod_next[P_WZ] = quat_w * quat_z;
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            prod_reg    <= prod_next;
            pos1_reg[0] <= pos_x;
            pos1_reg[1] <= pos_y;
            pos1_reg[2] <= pos_z;
            scl1_reg[0] <= scale_x;
            scl1_reg[1] <= scale_y;
            scl1_reg[2] <= scale_z;
        end
    end

    // Stage 2: rotation terms
    always_comb begin
        rot_next[0] = rot_diag(prod_reg[P_YY], prod_reg[P_ZZ]);
        rot_next[1] = rot_cross(prod_reg[P_XY], prod_reg[P_WZ], 1'b0);
        rot_next[2] = rot_cross(prod_reg[P_XZ], prod_reg[P_WY], 1'b1);
        rot_next[3] = rot_cross(prod_reg[P_XY], prod_reg[P_WZ], 1'b1);
        rot_next[4] = rot_diag(prod_reg[P_XX], prod_reg[P_ZZ]);
        rot_next[5] = rot_cross(prod_reg[P_YZ], prod_reg[P_WX], 1'b0);
        rot_next[6] = rot_cross(prod_reg[P_XZ], prod_reg[P_WY], 1'b0);
        rot_next[7] = rot_cross(prod_reg[P_YZ], prod_reg[P_WX], 1'b1);
        rot_next[8] = rot_diag(prod_reg[P_XX], prod_reg[P_YY]);
    end

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            rot_reg  <= rot_next;
            pos2_reg <= pos1_reg;
            scl2_reg <= scl1_reg;
        end
    end

    // Stage 3: scale each row, round to 2^-24
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                scaled[3*i+j] = (50'(rot_reg[3*i+j]) * 50'(scl2_reg[i]))
                                + 50'sd131072;
                mat_next.r[i][j] = 32'(scaled[3*i+j] >>> 18);
            end
            mat_next.t[i] = pos2_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            mat_reg <= mat_next;
        end
    end

    assign mat = mat_reg;

endmodule

FILE: hw/rtl/stc_rowseq.sv
// ============================================================================
// stc_rowseq
// Holds one local matrix and issues its four rows, one per cycle while the multiplier is ready.
// ============================================================================
module stc_rowseq (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      l_valid,
    input  stc_pkg::mat_t             l_mat,
    output logic                      l_take,
    input  logic                      mul_ready,
    output stc_pkg::row_ctl_t         ctl,
    output stc_pkg::elem_t [2:0]      op
);
    import stc_pkg::*;

    logic       busy_reg, busy_next;
    logic [1:0] row_reg, row_next;
    mat_t       hold_reg;
    logic       issue;

    assign issue  = busy_reg && mul_ready;
    assign l_take = l_valid && (!busy_reg || (issue && row_reg == LAST_ROW));

    // Row counter and busy flag
    always_comb begin
        busy_next = busy_reg;
        row_next  = row_reg;
        if (issue) begin
            row_next = row_reg + 2'd1;
            if (row_reg == LAST_ROW) begin
                busy_next = 1'b0;
            end
        end
        if (l_take) begin
            busy_next = 1'b1;
            row_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            row_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            row_reg  <= row_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (l_take) begin
            hold_reg <= l_mat;
        end
    end

    // Row operands: rotation row, or translation for the last row
    always_comb begin
        unique case (row_reg)
            2'd0:    op = hold_reg.r[0];
            2'd1:    op = hold_reg.r[1];
            2'd2:    op = hold_reg.r[2];
            default: op = hold_reg.t;
        endcase
    end

    assign ctl.valid = busy_reg;
    assign ctl.row   = row_reg;
    assign ctl.last  = (row_reg == LAST_ROW);

endmodule

FILE: hw/rtl/stc_rowmul.sv
// ============================================================================
// stc_rowmul
// Row times parent matrix: product, sum, round/saturate, output register.
// ============================================================================
module stc_rowmul (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  stc_pkg::row_ctl_t         ctl,
    input  stc_pkg::elem_t [2:0]      op,
    input  stc_pkg::mat_t             par,
    output logic                      in_ready,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [1:0]                m_row_index,
    output logic signed [47:0]        m_entry_0,
    output logic signed [47:0]        m_entry_1,
    output logic signed [47:0]        m_entry_2,
    output logic signed [47:0]        m_entry_3,
    output logic                      m_last_row
);
    import stc_pkg::*;

    logic               v1_reg, v2_reg, v3_reg;
    logic               en1, en2, en3;
    row_ctl_t           ctl1_reg, ctl2_reg;
    logic signed [63:0] prod_next [3][3];
    logic signed [63:0] prod_reg  [3][3];
    logic signed [65:0] sum_next  [3];
    logic signed [65:0] sum_reg   [3];
    logic signed [65:0] rnd       [3];
    logic signed [65:0] shifted   [3];
    logic signed [47:0] ent_next  [3];
    logic signed [47:0] ent_reg   [3];
    logic [1:0]         row_reg;
    logic               last_reg;

    assign en3      = !v3_reg || m_ready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= ctl.valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    // Stage 1: nine products
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
                prod_next[k][j] = 64'($signed(op[k])) * 64'($signed(par.r[k][j]));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            prod_reg <= prod_next;
            ctl1_reg <= ctl;
        end
    end

    // Stage 2: column sums, parent offset on the last row
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            sum_next[j] = 66'(prod_reg[0][j]) + 66'(prod_reg[1][j]) + 66'(prod_reg[2][j])
                        + (ctl1_reg.last ? (66'($signed(par.t[j])) <<< 24) : 66'sd0);
        end
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            sum_reg  <= sum_next;
            ctl2_reg <= ctl1_reg;
        end
    end

    // Stage 3: round to Q.16 and saturate to 48 bits
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            rnd[j] = sum_reg[j] + (ctl2_reg.last ? 66'sd32768 : 66'sd2147483648);
            shifted[j] = ctl2_reg.last ? (rnd[j] >>> 16) : (rnd[j] >>> 32);
            if (shifted[j] > 66'(SAT_MAX)) begin
                ent_next[j] = SAT_MAX;
            end else if (shifted[j] < 66'(SAT_MIN)) begin
                ent_next[j] = SAT_MIN;
            end else begin
                ent_next[j] = shifted[j][47:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en3) begin
            ent_reg  <= ent_next;
            row_reg  <= ctl2_reg.row;
            last_reg <= ctl2_reg.last;
        end
    end

    assign m_valid     = v3_reg;
    assign m_row_index = row_reg;
    assign m_entry_0   = ent_reg[0];
    assign m_entry_1   = ent_reg[1];
    assign m_entry_2   = ent_reg[2];
    assign m_entry_3   = last_reg ? ENTRY_ONE : 48'sd0;
    assign m_last_row  = last_reg;

endmodule

FILE: hw/rtl/scaled_transform_compose_core.sv
// ============================================================================
// scaled_transform_compose_core
// Builds a local affine matrix from quaternion/translation/scale, multiplies
// it by the parent matrix from configuration, emits four saturated rows.
// ============================================================================
//   channel   dir  handshake          beat
//   s_*       in   s_valid/s_ready    one local transform
//   m_*       out  m_valid/m_ready    one product row (four per transform)
//   cfg_wr_*  in   cfg_wr_en          one register write, no wait
//
// Input acceptance is paced by the row sequencer issuing one row per cycle
// into the multiplier while it is ready. First-row m_valid follows the beat
// through the build stages, sequencer hold register and multiplier stages.
// Reset clears all valid bits and restores the register defaults. Stalls on
// m_ready back up through every stage with nothing dropped or repeated.
`include "scaled_transform_compose_core_defines.svh"

module scaled_transform_compose_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [2:0]           cfg_wr_addr,
    input  logic [63:0]          cfg_wr_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic signed [15:0]   s_quat_x,
    input  logic signed [15:0]   s_quat_y,
    input  logic signed [15:0]   s_quat_z,
    input  logic signed [15:0]   s_quat_w,
    input  logic signed [31:0]   s_pos_x,
    input  logic signed [31:0]   s_pos_y,
    input  logic signed [31:0]   s_pos_z,
    input  logic signed [15:0]   s_scale_x,
    input  logic signed [15:0]   s_scale_y,
    input  logic signed [15:0]   s_scale_z,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_row_index,
    output logic signed [47:0]   m_entry_0,
    output logic signed [47:0]   m_entry_1,
    output logic signed [47:0]   m_entry_2,
    output logic signed [47:0]   m_entry_3,
    output logic                 m_last_row
);
    import stc_pkg::*;

    logic [63:0]        par_rot_reg;
    logic signed [31:0] par_off_reg [3];
    logic signed [15:0] par_scl_reg [3];
    logic               v1_reg, v2_reg, v3_reg;
    logic               en1, en2, en3;
    logic               l_take;
    logic               mul_ready;
    mat_t               loc_mat;
    mat_t               par_mat;
    row_ctl_t           row_ctl;
    elem_t [2:0]        row_op;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            par_rot_reg    <= PARENT_ROT_RESET;
            par_off_reg[0] <= '0;
            par_off_reg[1] <= '0;
            par_off_reg[2] <= '0;
            par_scl_reg[0] <= SCALE_ONE;
            par_scl_reg[1] <= SCALE_ONE;
            par_scl_reg[2] <= SCALE_ONE;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_addr)
                REG_PARENT_ROTATION: par_rot_reg    <= cfg_wr_data;
                REG_PARENT_OFFSET_X: par_off_reg[0] <= cfg_wr_data[31:0];
                REG_PARENT_OFFSET_Y: par_off_reg[1] <= cfg_wr_data[31:0];
                REG_PARENT_OFFSET_Z: par_off_reg[2] <= cfg_wr_data[31:0];
                REG_PARENT_SCALE_X:  par_scl_reg[0] <= cfg_wr_data[15:0];
                REG_PARENT_SCALE_Y:  par_scl_reg[1] <= cfg_wr_data[15:0];
                REG_PARENT_SCALE_Z:  par_scl_reg[2] <= cfg_wr_data[15:0];
                default: ;
            endcase
        end
    end

    // Parent matrix, free running; a write settles through the build stages
    stc_build u_par_build (
        .aclk     (aclk),
        .stage_en (3'b111),
        .quat_x   (par_rot_reg[15:0]),
        .quat_y   (par_rot_reg[31:16]),
        .quat_z   (par_rot_reg[47:32]),
        .quat_w   (par_rot_reg[63:48]),
        .pos_x    (par_off_reg[0]),
        .pos_y    (par_off_reg[1]),
        .pos_z    (par_off_reg[2]),
        .scale_x  (par_scl_reg[0]),
        .scale_y  (par_scl_reg[1]),
        .scale_z  (par_scl_reg[2]),
        .mat      (par_mat)
    );

    // Local build pipeline control
    assign en3     = !v3_reg || l_take;
    assign en2     = !v2_reg || en3;
    assign en1     = !v1_reg || en2;
    assign s_ready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    stc_build u_loc_build (
        .aclk     (aclk),
        .stage_en ({en3, en2, en1}),
        .quat_x   (s_quat_x),
        .quat_y   (s_quat_y),
        .quat_z   (s_quat_z),
        .quat_w   (s_quat_w),
        .pos_x    (s_pos_x),
        .pos_y    (s_pos_y),
        .pos_z    (s_pos_z),
        .scale_x  (s_scale_x),
        .scale_y  (s_scale_y),
        .scale_z  (s_scale_z),
        .mat      (loc_mat)
    );

    stc_rowseq u_rowseq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .l_valid   (v3_reg),
        .l_mat     (loc_mat),
        .l_take    (l_take),
        .mul_ready (mul_ready),
        .ctl       (row_ctl),
        .op        (row_op)
    );

    stc_rowmul u_rowmul (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (row_ctl),
        .op          (row_op),
        .par         (par_mat),
        .in_ready    (mul_ready),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_row_index (m_row_index),
        .m_entry_0   (m_entry_0),
        .m_entry_1   (m_entry_1),
        .m_entry_2   (m_entry_2),
        .m_entry_3   (m_entry_3),
        .m_last_row  (m_last_row)
    );

    // Checks
    `STC_ASSERT(a_take_needs_matrix, l_take |-> v3_reg, "sequencer took an empty matrix slot")
    `STC_ASSERT(a_col3_shape, m_valid |-> (m_entry_3 == (m_last_row ? ENTRY_ONE : 48'sd0)), "column 3 mismatch")
    `STC_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_entry_0), "beat changed")
    `STC_ASSERT(a_stall_full, !s_ready |-> (v1_reg && v2_reg && v3_reg), "input stalled with a bubble in the build pipe")

endmodule
